// ----- rtl/lfpd_pkg.sv -----
// Package for the line follower PD drive block: widths, register indexes,
// reset values and the gain bundle. Used by every module of the block.
`default_nettype none

package lfpd_pkg;

	localparam int SENS_W     = 8;
	localparam int ERR_W      = 4;
	localparam int STEER_W    = 16;
	localparam int GAIN_W     = 10;
	localparam int BASE_W     = 9;
	localparam int DUTY_W     = 9;
	localparam int SUM_W      = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic signed [ERR_W-1:0] ERR_LOST_POS = 4'sd5;
	localparam logic signed [ERR_W-1:0] ERR_LOST_NEG = -4'sd5;
	localparam logic signed [ERR_W-1:0] ERR_ZERO     = 4'sd0;

	localparam logic signed [SUM_W:0] SUM_MAX = 12'sd1023;
	localparam logic signed [SUM_W:0] SUM_MIN = -12'sd1023;

	localparam logic [DUTY_W-1:0] DUTY_FULL = 9'd256;

	localparam logic [GAIN_W-1:0] RST_GAIN_P      = 10'd51;
	localparam logic [GAIN_W-1:0] RST_GAIN_I      = 10'd0;
	localparam logic [GAIN_W-1:0] RST_GAIN_D      = 10'd230;
	localparam logic [GAIN_W-1:0] RST_GAIN_P_LOST = 10'd41;
	localparam logic [GAIN_W-1:0] RST_GAIN_D_LOST = 10'd192;
	localparam logic [BASE_W-1:0] RST_BASE_SPEED  = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_GAIN_P_LOST = 3'd3,
		REG_GAIN_D_LOST = 3'd4,
		REG_BASE_SPEED  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] p;
		logic [GAIN_W-1:0] i;
		logic [GAIN_W-1:0] d;
		logic [GAIN_W-1:0] p_lost;
		logic [GAIN_W-1:0] d_lost;
	} lfpd_gains_t;

endpackage

`default_nettype wire

// ----- rtl/lfpd_pid.sv -----
// Line error encoder and PID steer update with its state registers.
// Depends on lfpd_pkg for widths, limits and the gain bundle.
`default_nettype none

module lfpd_pid
	import lfpd_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic [SENS_W-1:0]         sensor_raw,
	input  wire logic                      sample_due,
	input  wire lfpd_gains_t               gains,
	output logic signed [ERR_W-1:0]        err,
	output logic signed [STEER_W-1:0]      steer
);

	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [SUM_W-1:0]   error_sum_q;
	logic signed [STEER_W-1:0] held_steer_q;

	logic [SENS_W-1:0]         s;
	logic                      all_dark;
	logic                      lost;
	logic signed [SUM_W:0]     sum_inc;
	logic signed [SUM_W-1:0]   sum_next;
	logic signed [SUM_W-1:0]   sum_used;
	logic [GAIN_W-1:0]         kp;
	logic [GAIN_W-1:0]         kd;
	logic signed [4:0]         deriv;
	logic signed [14:0]        prod_p;
	logic signed [21:0]        prod_i;
	logic signed [15:0]        prod_d;
	logic signed [22:0]        pid_sum;
	logic signed [STEER_W-1:0] pid_sat;

	assign s        = ~sensor_raw;
	assign all_dark = (sensor_raw == 8'hFF);

	always_comb begin
		if (all_dark && !prev_err_q[ERR_W-1] && prev_err_q != ERR_ZERO) begin
			err = ERR_LOST_POS;
		end else if (all_dark && prev_err_q[ERR_W-1]) begin
			err = ERR_LOST_NEG;
		end else if (s[3] && s[4]) begin
			err = 4'sd0;
		end else if (s[5] && !s[6]) begin
			err = 4'sd1;
		end else if (s[2] && !s[1]) begin
			err = -4'sd1;
		end else if (s[5] && s[6] && !s[7]) begin
			err = 4'sd2;
		end else if (s[2] && s[1]) begin
			err = -4'sd2;
		end else if (s[6] && s[7]) begin
			err = 4'sd3;
		end else if (s[1] && s[0]) begin
			err = -4'sd3;
		end else if (!s[6] && s[7]) begin
			err = 4'sd4;
		end else if (!s[1] && s[0]) begin
			err = -4'sd4;
		end else begin
			err = ERR_ZERO;
		end
	end

	assign lost = (err == ERR_LOST_POS) || (err == ERR_LOST_NEG);

	always_comb begin
		sum_inc = (SUM_W+1)'(error_sum_q) + (SUM_W+1)'(err);
		if (sum_inc > SUM_MAX) begin
			sum_next = SUM_W'(SUM_MAX);
		end else if (sum_inc < SUM_MIN) begin
			sum_next = SUM_W'(SUM_MIN);
		end else begin
			sum_next = sum_inc[SUM_W-1:0];
		end
	end

	always_comb begin
		if (lost) begin
			sum_used = error_sum_q;
			kp       = gains.p_lost;
			kd       = gains.d_lost;
			deriv    = err[ERR_W-1] ? -5'sd1 : 5'sd1;
		end else begin
			sum_used = sum_next;
			kp       = gains.p;
			kd       = gains.d;
			deriv    = 5'(err) - 5'(prev_err_q);
		end
	end

	assign prod_p  = $signed({1'b0, kp}) * err;
	assign prod_i  = $signed({1'b0, gains.i}) * sum_used;
	assign prod_d  = $signed({1'b0, kd}) * deriv;
	assign pid_sum = 23'(prod_p) + 23'(prod_i) + 23'(prod_d);

	always_comb begin
		if (pid_sum > 23'sd32767) begin
			pid_sat = 16'sh7FFF;
		end else if (pid_sum < -23'sd32768) begin
			pid_sat = 16'sh8000;
		end else begin
			pid_sat = pid_sum[STEER_W-1:0];
		end
	end

	assign steer = sample_due ? pid_sat : held_steer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q   <= '0;
			error_sum_q  <= '0;
			held_steer_q <= '0;
		end else if (en && sample_due) begin
			prev_err_q   <= err;
			error_sum_q  <= sum_used;
			held_steer_q <= pid_sat;
		end
	end

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && sample_due) |=> $stable(held_steer_q) && $stable(prev_err_q)
			&& $stable(error_sum_q))
		else $error("PID state changed without a due request");

	a_lost_keeps_sum: assert property (@(posedge clk) disable iff (!arst_n)
		en && sample_due && lost |=> $stable(error_sum_q))
		else $error("Integral changed while the line was lost");

	a_sum_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		en && sample_due |=> error_sum_q <= 11'sd1023 && error_sum_q >= -11'sd1023
			&& prev_err_q == $past(err))
		else $error("Integral out of range or last error not taken");

endmodule

`default_nettype wire

// ----- rtl/lfpd_drive.sv -----
// One motor channel: magnitude of base speed plus or minus the steer value,
// clamped to full duty, with a reverse bit. Depends on lfpd_pkg for widths.
`default_nettype none

module lfpd_drive
	import lfpd_pkg::*;
(
	input  wire logic [BASE_W-1:0]          base_speed,
	input  wire logic signed [STEER_W-1:0]  steer,
	input  wire logic                       negate,
	output logic [DUTY_W-1:0]               duty,
	output logic                            reverse
);

	logic signed [17:0] steer_ext;
	logic signed [17:0] term;
	logic signed [17:0] v;
	logic [17:0]        mag;

	assign steer_ext = 18'(steer);
	assign term      = negate ? -steer_ext : steer_ext;
	assign v         = $signed({9'b0, base_speed}) + term;
	assign mag       = v[17] ? 18'(-v) : 18'(v);
	assign duty      = (mag > 18'(DUTY_FULL)) ? DUTY_FULL : mag[DUTY_W-1:0];
	assign reverse   = v[17];

endmodule

`default_nettype wire

// ----- rtl/line_follow_pd_drive.sv -----
// Line follower PD drive: top level with configuration registers and the
// three-stage request pipeline. Depends on lfpd_pkg, lfpd_pid, lfpd_drive.
//
// A request carries eight raw line-sensor bits and a sample-due flag on a
// valid/ready channel. Each request gives one result on the output channel:
// the encoded line error, the new or held steer value and both motor duties
// with their reverse bits. Requests pass an input register, the PID stage
// (error encoder, integral and steer state) and the output register. One
// request is taken every cycle unless the receiver stalls; the PID state
// updates as a due request leaves the input register, so back-to-back requests
// each see the state left by the one before. When the receiver stalls, the
// stages fill and ready drops once all three hold a request; nothing is lost.
// Reset empties the pipeline, clears the PID state and loads the default
// gains and base speed. Configuration writes take effect at once; the user
// must make them while no request is in flight, as the block does not check.
`default_nettype none

module line_follow_pd_drive
	import lfpd_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [SENS_W-1:0]          sensor_raw,
	input  wire logic                       sample_due,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [ERR_W-1:0]         line_error,
	output logic signed [STEER_W-1:0]       steer_value,
	output logic [DUTY_W-1:0]               right_duty,
	output logic [DUTY_W-1:0]               left_duty,
	output logic                            right_reverse,
	output logic                            left_reverse
);

	lfpd_gains_t              gains_q;
	logic [BASE_W-1:0]        base_speed_q;

	logic                     v_s1;
	logic [SENS_W-1:0]        sensor_s1;
	logic                     due_s1;
	logic                     v_s2;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [STEER_W-1:0] steer_s2;
	logic                     v_s3;

	logic                     adv1;
	logic                     adv2;
	logic                     take;
	logic signed [ERR_W-1:0]  err_c;
	logic signed [STEER_W-1:0] steer_c;
	logic [DUTY_W-1:0]        rduty_c;
	logic [DUTY_W-1:0]        lduty_c;
	logic                     rrev_c;
	logic                     lrev_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.p      <= RST_GAIN_P;
			gains_q.i      <= RST_GAIN_I;
			gains_q.d      <= RST_GAIN_D;
			gains_q.p_lost <= RST_GAIN_P_LOST;
			gains_q.d_lost <= RST_GAIN_D_LOST;
			base_speed_q   <= RST_BASE_SPEED;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_P:      gains_q.p      <= cfg_data;
				REG_GAIN_I:      gains_q.i      <= cfg_data;
				REG_GAIN_D:      gains_q.d      <= cfg_data;
				REG_GAIN_P_LOST: gains_q.p_lost <= cfg_data;
				REG_GAIN_D_LOST: gains_q.d_lost <= cfg_data;
				REG_BASE_SPEED:  base_speed_q   <= cfg_data[BASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv2     = v_s2 && (!v_s3 || out_ready);
	assign adv1     = v_s1 && (!v_s2 || adv2);
	assign in_ready = !v_s1 || adv1;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (out_ready) begin
				v_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sensor_s1 <= sensor_raw;
			due_s1    <= sample_due;
		end
		if (adv1) begin
			err_s2   <= err_c;
			steer_s2 <= steer_c;
		end
		if (adv2) begin
			line_error    <= err_s2;
			steer_value   <= steer_s2;
			right_duty    <= rduty_c;
			left_duty     <= lduty_c;
			right_reverse <= rrev_c;
			left_reverse  <= lrev_c;
		end
	end

	assign out_valid = v_s3;

	lfpd_pid u_pid (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv1),
		.sensor_raw (sensor_s1),
		.sample_due (due_s1),
		.gains      (gains_q),
		.err        (err_c),
		.steer      (steer_c)
	);

	lfpd_drive u_drive_right (
		.base_speed (base_speed_q),
		.steer      (steer_s2),
		.negate     (1'b0),
		.duty       (rduty_c),
		.reverse    (rrev_c)
	);

	lfpd_drive u_drive_left (
		.base_speed (base_speed_q),
		.steer      (steer_s2),
		.negate     (1'b1),
		.duty       (lduty_c),
		.reverse    (lrev_c)
	);

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv1 |=> v_s1)
		else $error("Input stage dropped a stalled request");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv2 |=> v_s2 && $stable(steer_s2) && $stable(err_s2))
		else $error("PID stage lost a stalled request");

	a_reverse_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (right_reverse || left_reverse) |->
			(!right_reverse || right_duty != '0) && (!left_reverse || left_duty != '0))
		else $error("Reverse flagged with zero duty");

endmodule

`default_nettype wire

// ----- tb/lfpd_score_pkg.sv -----
// Steering predictor and result checker for the line follower PD drive testbench.
// Depends on lfpd_pkg for widths, register indexes and reset values.

package lfpd_score_pkg;
	import lfpd_pkg::*;

	typedef struct packed {
		logic signed [ERR_W-1:0]   line_error;
		logic signed [STEER_W-1:0] steer;
		logic [DUTY_W-1:0]         right_duty;
		logic [DUTY_W-1:0]         left_duty;
		logic                      right_rev;
		logic                      left_rev;
	} drive_cmd_t;

	class steer_tracker;
		logic [GAIN_W-1:0]         gain_p;
		logic [GAIN_W-1:0]         gain_i;
		logic [GAIN_W-1:0]         gain_d;
		logic [GAIN_W-1:0]         gain_p_lost;
		logic [GAIN_W-1:0]         gain_d_lost;
		logic [BASE_W-1:0]         base_speed;
		logic signed [ERR_W-1:0]   prev_err;
		logic signed [SUM_W-1:0]   error_sum;
		logic signed [STEER_W-1:0] held_steer;
		drive_cmd_t                awaited[$];
		int                        failures;

		function new();
			gain_p = RST_GAIN_P;
			gain_i = RST_GAIN_I;
			gain_d = RST_GAIN_D;
			gain_p_lost = RST_GAIN_P_LOST;
			gain_d_lost = RST_GAIN_D_LOST;
			base_speed = RST_BASE_SPEED;
			prev_err = '0;
			error_sum = '0;
			held_steer = '0;
			failures = 0;
		endfunction

		function void set_reg(cfg_reg_t index, logic [CFG_DATA_W-1:0] value);
			case (index)
				REG_GAIN_P: gain_p = value;
				REG_GAIN_I: gain_i = value;
				REG_GAIN_D: gain_d = value;
				REG_GAIN_P_LOST: gain_p_lost = value;
				REG_GAIN_D_LOST: gain_d_lost = value;
				REG_BASE_SPEED: base_speed = value[BASE_W-1:0];
				default: ;
			endcase
		endfunction

		// A sensor sees the line when its bit is low; the first matching rule wins.
		function logic signed [ERR_W-1:0] line_position(logic [SENS_W-1:0] raw);
			logic [SENS_W-1:0] s;
			s = ~raw;
			if (raw == '1 && prev_err > 0) return ERR_LOST_POS;
			if (raw == '1 && prev_err < 0) return ERR_LOST_NEG;
			if (s[3] && s[4]) return ERR_ZERO;
			if (s[5] && !s[6]) return 4'sd1;
			if (s[2] && !s[1]) return -4'sd1;
			if (s[5] && s[6] && !s[7]) return 4'sd2;
			if (s[2] && s[1]) return -4'sd2;
			if (s[6] && s[7]) return 4'sd3;
			if (s[1] && s[0]) return -4'sd3;
			if (!s[6] && s[7]) return 4'sd4;
			if (!s[1] && s[0]) return -4'sd4;
			return ERR_ZERO;
		endfunction

		function void motor(int level, output logic [DUTY_W-1:0] duty, output logic rev);
			int mag;
			mag = level < 0 ? -level : level;
			if (mag > 256) mag = 256;
			duty = mag[DUTY_W-1:0];
			rev = level < 0;
		endfunction

		function void note_request(logic [SENS_W-1:0] raw, logic due);
			logic signed [ERR_W-1:0] err;
			int e, kp, kd, slope, acc;
			drive_cmd_t cmd;
			err = line_position(raw);
			e = err;
			if (due) begin
				if (e > 4 || e < -4) begin
					kp = gain_p_lost;
					kd = gain_d_lost;
					slope = e > 0 ? 1 : -1;
				end else begin
					acc = int'(error_sum) + e;
					if (acc > 1023) acc = 1023;
					if (acc < -1023) acc = -1023;
					error_sum = acc[SUM_W-1:0];
					kp = gain_p;
					kd = gain_d;
					slope = e - int'(prev_err);
				end
				acc = kp * e + int'(gain_i) * int'(error_sum) + kd * slope;
				if (acc > 32767) acc = 32767;
				if (acc < -32768) acc = -32768;
				held_steer = acc[STEER_W-1:0];
				prev_err = err;
			end
			cmd.line_error = err;
			cmd.steer = held_steer;
			motor(int'(base_speed) + int'(held_steer), cmd.right_duty, cmd.right_rev);
			motor(int'(base_speed) - int'(held_steer), cmd.left_duty, cmd.left_rev);
			awaited.push_back(cmd);
		endfunction

		function void check_drive(drive_cmd_t got);
			drive_cmd_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("Result with no request pending: err %0d steer %0d", got.line_error,
						got.steer);
				return;
			end
			want = awaited.pop_front();
			if (got.line_error !== want.line_error || got.steer !== want.steer ||
				got.right_duty !== want.right_duty || got.left_duty !== want.left_duty ||
				got.right_rev !== want.right_rev || got.left_rev !== want.left_rev) begin
				failures++;
				if (failures <= 10) begin
					$display("Mismatch: expected err %0d steer %0d R %0d/%0b L %0d/%0b",
						want.line_error, want.steer, want.right_duty, want.right_rev,
						want.left_duty, want.left_rev);
					$display("          got err %0d steer %0d R %0d/%0b L %0d/%0b",
						got.line_error, got.steer, got.right_duty, got.right_rev,
						got.left_duty, got.left_rev);
				end
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

endpackage

// ----- tb/line_follow_pd_drive_test.sv -----
// Top-level testbench for line_follow_pd_drive: directed and random sensor requests
// under several gain settings, checked against steer_tracker. Depends on lfpd_pkg.

module line_follow_pd_drive_test;
	import lfpd_pkg::*;
	import lfpd_score_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	// Line patterns from the middle out to the edges, then two near the middle.
	localparam logic [12:0][7:0] TRACKS = {8'hE7, 8'hEF, 8'hF7, 8'hDF, 8'hFB, 8'h9F,
		8'hF9, 8'h3F, 8'hFC, 8'h7F, 8'hFE, 8'hCF, 8'hF3};

	// Sensor bits and sample flag; listed from the top down.
	localparam logic [21:0][8:0] PROBES = {
		{8'hFF, 1'b1}, {8'hE7, 1'b1}, {8'hDF, 1'b1}, {8'hFF, 1'b1},
		{8'hFF, 1'b0}, {8'hFB, 1'b1}, {8'hFF, 1'b1}, {8'h9F, 1'b1},
		{8'hF9, 1'b1}, {8'h3F, 1'b0}, {8'h3F, 1'b1}, {8'hFC, 1'b1},
		{8'h7F, 1'b1}, {8'hFE, 1'b1}, {8'h00, 1'b1}, {8'h55, 1'b0},
		{8'hAA, 1'b1}, {8'hFF, 1'b1}, {8'hF3, 1'b1}, {8'hCF, 1'b1},
		{8'h7E, 1'b1}, {8'h81, 1'b0}};

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic [SENS_W-1:0]           sensor_raw;
	logic                        sample_due;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [ERR_W-1:0]     line_error;
	logic signed [STEER_W-1:0]   steer_value;
	logic [DUTY_W-1:0]           right_duty;
	logic [DUTY_W-1:0]           left_duty;
	logic                        right_reverse;
	logic                        left_reverse;

	steer_tracker tracker;
	int cycles = 0;
	bit calm;
	bit stall_req;
	int stall_left;

	line_follow_pd_drive dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sensor_raw(sensor_raw),
		.sample_due(sample_due),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_error(line_error),
		.steer_value(steer_value),
		.right_duty(right_duty),
		.left_duty(left_duty),
		.right_reverse(right_reverse),
		.left_reverse(left_reverse)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			tracker.note_request(sensor_raw, sample_due);
		if (out_valid && out_ready)
			tracker.check_drive({line_error, steer_value, right_duty, left_duty,
				right_reverse, left_reverse});
	end

	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		forever @(negedge clk) begin
			if (stall_req) begin
				stall_req = 1'b0;
				stall_left = 60;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= calm || ($urandom_range(99) >= 13);
		end
	end

	function automatic logic [7:0] pick_sensor(int lean);
		int roll;
		if (lean != 0 && $urandom_range(99) < 88)
			return lean > 0 ? 8'h7F : 8'hFE;
		roll = $urandom_range(99);
		if (roll < 15) return 8'hFF;
		if (roll < 45) return TRACKS[4'($urandom_range(12))];
		return 8'($urandom);
	endfunction

	task automatic offer(logic [7:0] raw, logic due);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sensor_raw <= raw;
		sample_due <= due;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t index, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value[CFG_DATA_W-1:0];
		tracker.set_reg(index, value[CFG_DATA_W-1:0]);
	endtask

	task automatic load_setting(int gp, int gi, int gd, int gpl, int gdl, int base);
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_GAIN_P_LOST, gpl);
		write_reg(REG_GAIN_D_LOST, gdl);
		write_reg(REG_BASE_SPEED, base);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A leaning run keeps steering one way until the integral passes the goal.
	task automatic run_random(int count, int lean, int goal);
		int n;
		bit busy;
		n = 0;
		busy = 1'b1;
		while (busy) begin
			offer(pick_sensor(lean), $urandom_range(99) < (lean != 0 ? 95 : 70));
			n++;
			if (lean > 0)
				busy = (n < count || tracker.error_sum < goal) && n < 800;
			else if (lean < 0)
				busy = (n < count || tracker.error_sum > goal) && n < 800;
			else
				busy = n < count;
		end
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sensor_raw = '0;
		sample_due = 1'b0;
		calm = 1'b0;
		stall_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 21; i >= 0; i--)
			offer(PROBES[i][8:1], PROBES[i][0]);

		calm = 1'b1;
		load_setting(1023, 1023, 1023, 1023, 1023, 256);
		run_random(30, -1, -1023);
		calm = 1'b0;

		load_setting(0, 0, 0, 0, 0, 0);
		run_random(40, 0, 0);

		load_setting($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
			$urandom_range(1023), $urandom_range(1023), 128);
		run_random(30, 1, -700);

		load_setting(1023, 1023, 1023, 1023, 1023, 0);
		run_random(25, 0, 0);
		stall_req = 1'b1;
		run_random(40, 0, 0);

		load_setting(51, 4, 230, 41, 192, 384);
		run_random(30, 0, 0);
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		run_random(30, 0, 0);

		load_setting($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
			$urandom_range(1023), $urandom_range(1023), $urandom_range(256));
		run_random(60, 0, 0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
